@@ design/kpnc_pkg.sv @@
// Shared types, constants and tables for the keyboard piano note controller.
`default_nettype none
package kpnc_pkg;

    // Input transaction: one decoded key event or a start command
    typedef struct packed {
        logic       operation;
        logic [7:0] scancode;
        logic       pressed;
        logic [6:0] ascii;
    } key_item_t;

    // Output transaction: one synth register write
    typedef struct packed {
        logic [3:0]  reg_index;
        logic [31:0] reg_data;
        logic        last_write;
    } wr_item_t;

    // Command kinds passed from the front end to the write sequencer
    typedef enum logic [1:0] {
        CMD_OSC  = 2'd0,   // control word, then oscillator preset (six words)
        CMD_FM   = 2'd1,   // control word, then FM preset (four words)
        CMD_QUIT = 2'd2,   // control word, then both notes zeroed
        CMD_NOTE = 2'd3    // single note write, phase looked up from note number
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] idx;    // note register for CMD_NOTE
        logic [6:0] note;   // note number for CMD_NOTE (out of range gives zero)
        logic [2:0] ctrl;   // control word for the other kinds
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Sizes
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_WRITES  = 7;
    localparam int STEP_W      = $clog2(MAX_WRITES);

    // Operation codes
    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_START = 1'b1;

    // Special scancodes and characters
    localparam logic [7:0] SC_TAB      = 8'h0D;
    localparam logic [7:0] SC_CAPSLOCK = 8'h58;
    localparam logic [7:0] SC_NUMLOCK  = 8'h77;
    localparam logic [6:0] CH_Q_LO     = 7'h71;
    localparam logic [6:0] CH_Q_UP     = 7'h51;
    localparam logic [6:0] CH_M_LO     = 7'h6D;
    localparam logic [6:0] CH_M_UP     = 7'h4D;

    // Note limits
    localparam logic [6:0] BASE_RESET = 7'd60;
    localparam logic [6:0] BASE_LOW   = 7'd36;
    localparam logic [6:0] BASE_HIGH  = 7'd96;
    localparam logic [6:0] OCTAVE     = 7'd12;
    localparam logic [6:0] MIDI_LO    = 7'd21;
    localparam logic [6:0] MIDI_HI    = 7'd108;
    localparam logic [4:0] SEMI_MAX   = 5'd16;

    // Control word values
    localparam logic [2:0] CTRL_START = 3'd0;
    localparam logic [2:0] CTRL_MUTE  = 3'd1;

    // Synth register indexes
    localparam logic [3:0] REG_CTRL       = 4'd0;
    localparam logic [3:0] REG_LEFT_NOTE  = 4'd2;
    localparam logic [3:0] REG_OSC_A      = 4'd3;
    localparam logic [3:0] REG_OSC_B      = 4'd4;
    localparam logic [3:0] REG_OSC_C      = 4'd5;
    localparam logic [3:0] REG_FM_A       = 4'd6;
    localparam logic [3:0] REG_FM_B       = 4'd7;
    localparam logic [3:0] REG_RIGHT_NOTE = 4'd8;
    localparam logic [3:0] REG_OSC_D      = 4'd9;
    localparam logic [3:0] REG_OSC_E      = 4'd10;
    localparam logic [3:0] REG_OSC_F      = 4'd11;
    localparam logic [3:0] REG_FM_C       = 4'd12;
    localparam logic [3:0] REG_FM_D       = 4'd13;
    localparam logic [3:0] REG_LAST       = 4'd13;

    // Preset data words
    localparam logic [31:0] OSC_A_DATA = 32'h0000_C800;
    localparam logic [31:0] OSC_B_DATA = 32'h0000_6402;
    localparam logic [31:0] OSC_C_DATA = 32'h0000_5003;
    localparam logic [31:0] OSC_D_DATA = 32'h0000_C801;
    localparam logic [31:0] OSC_E_DATA = 32'h0000_7800;
    localparam logic [31:0] OSC_F_DATA = 32'h0000_0000;
    localparam logic [31:0] FM_A_DATA  = 32'h0000_4002;
    localparam logic [31:0] FM_B_DATA  = 32'h0000_486C;
    localparam logic [31:0] FM_C_DATA  = 32'h0000_6401;
    localparam logic [31:0] FM_D_DATA  = 32'h0000_6A4A;

    // Phase increment per note, MIDI_LO through MIDI_HI
    localparam logic [31:0] PHASE_ROM [88] = '{
        32'h00258BF2, 32'h0027C781, 32'h002A250C, 32'h002CA698,
        32'h002F4E4B, 32'h00321E69, 32'h00351958, 32'h003841A6,
        32'h003B9A04, 32'h003F254E, 32'h0042E68B, 32'h0046E0F0,
        32'h004B17E5, 32'h004F8F01, 32'h00544A17, 32'h00594D31,
        32'h005E9C96, 32'h00643CD2, 32'h006A32B1, 32'h0070834C,
        32'h00773407, 32'h007E4A9B, 32'h0085CD15, 32'h008DC1E1,
        32'h00962FC9, 32'h009F1E03, 32'h00A8942E, 32'h00B29A62,
        32'h00BD392D, 32'h00C879A3, 32'h00D46562, 32'h00E10697,
        32'h00EE680F, 32'h00FC9536, 32'h010B9A2B, 32'h011B83C2,
        32'h012C5F93, 32'h013E3C06, 32'h0151285D, 32'h016534C3,
        32'h017A725A, 32'h0190F347, 32'h01A8CAC3, 32'h01C20D2F,
        32'h01DCD01D, 32'h01F92A6D, 32'h02173456, 32'h02370783,
        32'h0258BF26, 32'h027C780B, 32'h02A250BA, 32'h02CA6987,
        32'h02F4E4B4, 32'h0321E68D, 32'h03519586, 32'h03841A5D,
        32'h03B9A03A, 32'h03F254D9, 32'h042E68AC, 32'h046E0F07,
        32'h04B17E4B, 32'h04F8F017, 32'h0544A173, 32'h0594D30D,
        32'h05E9C968, 32'h0643CD1B, 32'h06A32B0D, 32'h070834BA,
        32'h07734075, 32'h07E4A9B2, 32'h085CD157, 32'h08DC1E0D,
        32'h0962FC96, 32'h09F1E02D, 32'h0A8942E7, 32'h0B29A61A,
        32'h0BD392D0, 32'h0C879A35, 32'h0D46561A, 32'h0E106974,
        32'h0EE680E9, 32'h0FC95364, 32'h10B9A2AF, 32'h11B83C1A,
        32'h12C5F92C, 32'h13E3C05A, 32'h151285CE, 32'h16534C35
    };

endpackage
`default_nettype wire

@@ design/kpnc_front.sv @@
// Front end: accepts key events, tracks play state, queues write commands.
`default_nettype none
module kpnc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  key_valid,
    input  wire logic                  key_stall,
    input  wire kpnc_pkg::key_item_t   key_item,
    output kpnc_pkg::q_push_t          push_out
);
    import kpnc_pkg::*;

    // Left track: main keyboard keys
    function automatic logic [5:0] left_map(input logic [7:0] sc);
        logic [5:0] r;   // {hit, semitone}
        begin
            case (sc)
                8'h1C:   r = {1'b1, 5'd0};
                8'h1D:   r = {1'b1, 5'd1};
                8'h1B:   r = {1'b1, 5'd2};
                8'h24:   r = {1'b1, 5'd3};
                8'h23:   r = {1'b1, 5'd4};
                8'h2B:   r = {1'b1, 5'd5};
                8'h2D:   r = {1'b1, 5'd6};
                8'h34:   r = {1'b1, 5'd7};
                8'h2E:   r = {1'b1, 5'd8};
                8'h33:   r = {1'b1, 5'd9};
                8'h35:   r = {1'b1, 5'd10};
                8'h3B:   r = {1'b1, 5'd11};
                8'h42:   r = {1'b1, 5'd12};
                8'h43:   r = {1'b1, 5'd13};
                8'h4B:   r = {1'b1, 5'd14};
                8'h44:   r = {1'b1, 5'd15};
                8'h41:   r = {1'b1, 5'd16};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Right track: numpad keys
    function automatic logic [5:0] right_map(input logic [7:0] sc);
        logic [5:0] r;
        begin
            case (sc)
                8'h6C:   r = {1'b1, 5'd0};
                8'h75:   r = {1'b1, 5'd2};
                8'h7D:   r = {1'b1, 5'd4};
                8'h6B:   r = {1'b1, 5'd5};
                8'h73:   r = {1'b1, 5'd7};
                8'h74:   r = {1'b1, 5'd9};
                8'h69:   r = {1'b1, 5'd11};
                8'h72:   r = {1'b1, 5'd12};
                8'h7A:   r = {1'b1, 5'd14};
                8'h70:   r = {1'b1, 5'd16};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    logic       active_reg, active_next;
    logic [6:0] left_base_reg, left_base_next;
    logic [6:0] right_base_reg, right_base_next;
    logic       fm_mode_reg, fm_mode_next;
    logic       left_held_vld_reg, left_held_vld_next;
    logic [4:0] left_held_reg, left_held_next;
    logic       right_held_vld_reg, right_held_vld_next;
    logic [4:0] right_held_reg, right_held_next;
    logic [2:0] ctrl_reg, ctrl_next;

    logic       accept;
    logic [5:0] lmap, rmap;
    logic       is_quit, is_mode;

    assign accept  = key_valid && !key_stall;
    assign lmap    = left_map(key_item.scancode);
    assign rmap    = right_map(key_item.scancode);
    assign is_quit = (key_item.ascii == CH_Q_LO) || (key_item.ascii == CH_Q_UP);
    assign is_mode = (key_item.ascii == CH_M_LO) || (key_item.ascii == CH_M_UP);

    // Classify the transaction, update state, build the command
    always_comb
    begin
        active_next         = active_reg;
        left_base_next      = left_base_reg;
        right_base_next     = right_base_reg;
        fm_mode_next        = fm_mode_reg;
        left_held_vld_next  = left_held_vld_reg;
        left_held_next      = left_held_reg;
        right_held_vld_next = right_held_vld_reg;
        right_held_next     = right_held_reg;
        ctrl_next           = ctrl_reg;
        push_out.push       = 1'b0;
        push_out.cmd.kind   = CMD_NOTE;
        push_out.cmd.idx    = REG_LEFT_NOTE;
        push_out.cmd.note   = '0;
        push_out.cmd.ctrl   = ctrl_reg;

        if (accept)
        begin
            if (key_item.operation == OP_START)
            begin
                active_next         = 1'b1;
                left_base_next      = BASE_RESET;
                right_base_next     = BASE_RESET;
                fm_mode_next        = 1'b0;
                left_held_vld_next  = 1'b0;
                right_held_vld_next = 1'b0;
                ctrl_next           = CTRL_START;
                push_out.push       = 1'b1;
                push_out.cmd.kind   = CMD_OSC;
                push_out.cmd.ctrl   = CTRL_START;
            end
            else if (!active_reg)
            begin
                // ignored while inactive
            end
            else if (!key_item.pressed)
            begin
                // key maps are disjoint, so at most one track matches
                if (left_held_vld_reg && lmap[5] && (lmap[4:0] == left_held_reg))
                begin
                    left_held_vld_next = 1'b0;
                    push_out.push      = 1'b1;
                    push_out.cmd.idx   = REG_LEFT_NOTE;
                end
                else if (right_held_vld_reg && rmap[5] && (rmap[4:0] == right_held_reg))
                begin
                    right_held_vld_next = 1'b0;
                    push_out.push       = 1'b1;
                    push_out.cmd.idx    = REG_RIGHT_NOTE;
                end
            end
            else if (key_item.scancode == SC_TAB)
            begin
                if (left_base_reg > BASE_LOW)
                    left_base_next = left_base_reg - OCTAVE;
            end
            else if (key_item.scancode == SC_CAPSLOCK)
            begin
                if (left_base_reg < BASE_HIGH)
                    left_base_next = left_base_reg + OCTAVE;
            end
            else if (key_item.scancode == SC_NUMLOCK)
            begin
                if (right_base_reg < BASE_HIGH)
                    right_base_next = right_base_reg + OCTAVE;
            end
            else if (is_quit)
            begin
                ctrl_next         = CTRL_MUTE;
                active_next       = 1'b0;
                push_out.push     = 1'b1;
                push_out.cmd.kind = CMD_QUIT;
                push_out.cmd.ctrl = CTRL_MUTE;
            end
            else if (is_mode)
            begin
                // mode toggle clears bits 2:1 and puts the new mode in bit 1
                fm_mode_next      = !fm_mode_reg;
                ctrl_next         = {1'b0, !fm_mode_reg, ctrl_reg[0]};
                push_out.push     = 1'b1;
                push_out.cmd.kind = fm_mode_reg ? CMD_OSC : CMD_FM;
                push_out.cmd.ctrl = {1'b0, !fm_mode_reg, ctrl_reg[0]};
            end
            else if (lmap[5])
            begin
                left_held_vld_next = 1'b1;
                left_held_next     = lmap[4:0];
                push_out.push      = 1'b1;
                push_out.cmd.idx   = REG_LEFT_NOTE;
                push_out.cmd.note  = left_base_reg + 7'(lmap[4:0]);
            end
            else if (rmap[5])
            begin
                right_held_vld_next = 1'b1;
                right_held_next     = rmap[4:0];
                push_out.push       = 1'b1;
                push_out.cmd.idx    = REG_RIGHT_NOTE;
                push_out.cmd.note   = right_base_reg + 7'(rmap[4:0]);
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg         <= 1'b0;
            left_base_reg      <= BASE_RESET;
            right_base_reg     <= BASE_RESET;
            fm_mode_reg        <= 1'b0;
            left_held_vld_reg  <= 1'b0;
            left_held_reg      <= '0;
            right_held_vld_reg <= 1'b0;
            right_held_reg     <= '0;
            ctrl_reg           <= CTRL_START;
        end
        else
        begin
            active_reg         <= active_next;
            left_base_reg      <= left_base_next;
            right_base_reg     <= right_base_next;
            fm_mode_reg        <= fm_mode_next;
            left_held_vld_reg  <= left_held_vld_next;
            left_held_reg      <= left_held_next;
            right_held_vld_reg <= right_held_vld_next;
            right_held_reg     <= right_held_next;
            ctrl_reg           <= ctrl_next;
        end
    end

    // Held semitones stay within the key map
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        (left_held_vld_reg |-> left_held_reg <= SEMI_MAX) and
        (right_held_vld_reg |-> right_held_reg <= SEMI_MAX))
        else $error("held semitone out of range");

    // Control word mode bit follows the mode flag
    a_ctrl_mode: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ctrl_reg[1] == fm_mode_reg)
        else $error("control mode bit disagrees with mode");

endmodule
`default_nettype wire

@@ design/kpnc_queue.sv @@
// Command queue between the front end and the write sequencer.
`default_nettype none
module kpnc_queue #(
    parameter int DEPTH = kpnc_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kpnc_pkg::q_push_t   push_in,
    input  wire logic                pop,
    output kpnc_pkg::cmd_t           head,
    output kpnc_pkg::q_status_t      status
);
    import kpnc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push_in.push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_in.cmd;
    end

    // The front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push_in.push && status.full))
        else $error("command queue overflow");

endmodule
`default_nettype wire

@@ design/kpnc_back.sv @@
// Write sequencer: expands queued commands into synth register writes.
`default_nettype none
module kpnc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kpnc_pkg::cmd_t      head,
    input  wire kpnc_pkg::q_status_t status,
    output logic                     pop,
    output logic                     wr_valid,
    input  wire logic                wr_stall,
    output kpnc_pkg::wr_item_t       wr_item
);
    import kpnc_pkg::*;

    // Phase increment for a note, zero outside the keyboard range
    function automatic logic [31:0] phase_of(input logic [6:0] note);
        logic [6:0] off;
        begin
            off = note - MIDI_LO;
            if ((note < MIDI_LO) || (note > MIDI_HI))
                return '0;
            return PHASE_ROM[off];
        end
    endfunction

    logic              busy_reg, busy_next;
    cmd_t              cur_reg, cur_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              wr_valid_reg, wr_valid_next;
    wr_item_t          wr_item_reg, wr_item_next;
    logic              out_free, load;
    wr_item_t          wr_sel;

    assign out_free = !wr_valid_reg || !wr_stall;
    assign load     = busy_reg && out_free;
    assign pop      = !busy_reg && !status.empty;
    assign wr_valid = wr_valid_reg;
    assign wr_item  = wr_item_reg;

    // Write for the current command and step
    always_comb
    begin
        wr_sel.reg_index  = REG_CTRL;
        wr_sel.reg_data   = 32'(cur_reg.ctrl);
        wr_sel.last_write = 1'b0;
        case (cur_reg.kind)
            CMD_NOTE:
            begin
                wr_sel.reg_index  = cur_reg.idx;
                wr_sel.reg_data   = phase_of(cur_reg.note);
                wr_sel.last_write = 1'b1;
            end
            CMD_QUIT:
            begin
                case (step_reg)
                    STEP_W'(0): ;
                    STEP_W'(1):
                    begin
                        wr_sel.reg_index = REG_LEFT_NOTE;
                        wr_sel.reg_data  = '0;
                    end
                    default:
                    begin
                        wr_sel.reg_index  = REG_RIGHT_NOTE;
                        wr_sel.reg_data   = '0;
                        wr_sel.last_write = 1'b1;
                    end
                endcase
            end
            CMD_FM:
            begin
                case (step_reg)
                    STEP_W'(0): ;
                    STEP_W'(1):
                    begin
                        wr_sel.reg_index = REG_FM_A;
                        wr_sel.reg_data  = FM_A_DATA;
                    end
                    STEP_W'(2):
                    begin
                        wr_sel.reg_index = REG_FM_B;
                        wr_sel.reg_data  = FM_B_DATA;
                    end
                    STEP_W'(3):
                    begin
                        wr_sel.reg_index = REG_FM_C;
                        wr_sel.reg_data  = FM_C_DATA;
                    end
                    default:
                    begin
                        wr_sel.reg_index  = REG_FM_D;
                        wr_sel.reg_data   = FM_D_DATA;
                        wr_sel.last_write = 1'b1;
                    end
                endcase
            end
            default:
            begin
                // oscillator preset, also used by start
                case (step_reg)
                    STEP_W'(0): ;
                    STEP_W'(1):
                    begin
                        wr_sel.reg_index = REG_OSC_A;
                        wr_sel.reg_data  = OSC_A_DATA;
                    end
                    STEP_W'(2):
                    begin
                        wr_sel.reg_index = REG_OSC_B;
                        wr_sel.reg_data  = OSC_B_DATA;
                    end
                    STEP_W'(3):
                    begin
                        wr_sel.reg_index = REG_OSC_C;
                        wr_sel.reg_data  = OSC_C_DATA;
                    end
                    STEP_W'(4):
                    begin
                        wr_sel.reg_index = REG_OSC_D;
                        wr_sel.reg_data  = OSC_D_DATA;
                    end
                    STEP_W'(5):
                    begin
                        wr_sel.reg_index = REG_OSC_E;
                        wr_sel.reg_data  = OSC_E_DATA;
                    end
                    default:
                    begin
                        wr_sel.reg_index  = REG_OSC_F;
                        wr_sel.reg_data   = OSC_F_DATA;
                        wr_sel.last_write = 1'b1;
                    end
                endcase
            end
        endcase
    end

    // Sequencer and output register next state
    always_comb
    begin
        busy_next     = busy_reg;
        cur_next      = cur_reg;
        step_next     = step_reg;
        wr_valid_next = wr_valid_reg;
        wr_item_next  = wr_item_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            cur_next  = head;
            step_next = '0;
        end
        if (load)
        begin
            wr_valid_next = 1'b1;
            wr_item_next  = wr_sel;
            if (wr_sel.last_write)
                busy_next = 1'b0;
            else
                step_next = step_reg + 1'b1;
        end
        else if (out_free)
        begin
            wr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        wr_item_reg <= wr_item_next;
    end

    // Only defined synth registers are written
    a_index_legal: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> (wr_item_reg.reg_index != 4'd1) && (wr_item_reg.reg_index <= REG_LAST))
        else $error("write to undefined synth register");

    // A command never runs past its last write
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg < STEP_W'(MAX_WRITES))
        else $error("sequencer step out of range");

endmodule
`default_nettype wire

@@ design/keyboard_piano_note_controller_unit.sv @@
// An accepted transaction's command is queued, then popped into the sequencer once idle.
// Throughput: the front end takes one transaction per cycle while the command queue has room;
// the write sequencer sends a command's writes (1 to 7) one a cycle while not stalled.
// Reset (rst_n low, asynchronous): inactive, both base notes 60, oscillator mode,
// nothing held, control copy 0, command queue and output register empty.
`default_nettype none
module keyboard_piano_note_controller_unit #(
    parameter int QUEUE_DEPTH = kpnc_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                key_valid,
    output logic                     key_stall,
    input  wire kpnc_pkg::key_item_t key_item,
    output logic                     wr_valid,
    input  wire logic                wr_stall,
    output kpnc_pkg::wr_item_t       wr_item
);
    import kpnc_pkg::*;

    q_push_t   q_push;
    q_status_t q_status;
    cmd_t      q_head;
    logic      q_pop;

    assign key_stall = q_status.full;

    kpnc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key_item  (key_item),
        .push_out  (q_push)
    );

    kpnc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (q_push),
        .pop     (q_pop),
        .head    (q_head),
        .status  (q_status)
    );

    kpnc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .status   (q_status),
        .pop      (q_pop),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .wr_item  (wr_item)
    );

endmodule
`default_nettype wire

@@ verif/keyboard_piano_note_controller_unit_tb.sv @@
// Self-checking testbench for the keyboard piano note controller: directed and random key streams.
`timescale 1ns / 1ps
module keyboard_piano_note_controller_unit_tb;
    import kpnc_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [4:0] NO_SEMI = 5'h1F;

    // Scancodes of the playing keys and their semitone offsets
    localparam logic [7:0] LEFT_CODES [17] = '{
        8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42, 8'h4B, 8'h41,
        8'h1D, 8'h24, 8'h2D, 8'h2E, 8'h35, 8'h43, 8'h44
    };
    localparam logic [4:0] LEFT_SEMIS [17] = '{
        5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd9, 5'd11, 5'd12, 5'd14, 5'd16,
        5'd1, 5'd3, 5'd6, 5'd8, 5'd10, 5'd13, 5'd15
    };
    localparam logic [7:0] RIGHT_CODES [10] = '{
        8'h6C, 8'h75, 8'h7D, 8'h6B, 8'h73, 8'h74, 8'h69, 8'h72, 8'h7A, 8'h70
    };
    localparam logic [4:0] RIGHT_SEMIS [10] = '{
        5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd9, 5'd11, 5'd12, 5'd14, 5'd16
    };
    localparam logic [7:0] SC_KEY_M = 8'h3A;
    localparam logic [7:0] SC_KEY_Q = 8'h15;
    localparam logic [6:0] CH_SPACE = 7'h20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      key_valid = 1'b0;
    logic      key_stall;
    key_item_t key_item = '0;
    logic      wr_valid;
    logic      wr_stall = 1'b0;
    wr_item_t  wr_item;

    // Mirror of the note controller state
    logic       keys_live;
    logic [6:0] left_base;
    logic [6:0] right_base;
    logic       fm_on;
    logic [4:0] left_hold;
    logic [4:0] right_hold;
    logic [2:0] ctrl_copy;

    wr_item_t expected_writes[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       stall_mode = 0;
    int       stall_hold = 0;

    keyboard_piano_note_controller_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key_item  (key_item),
        .wr_valid  (wr_valid),
        .wr_stall  (wr_stall),
        .wr_item   (wr_item)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stall pattern: modes change at random intervals
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_hold <= $urandom_range(32, 400);
        end
        else
        begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            0:       wr_stall <= 1'b0;
            1:       wr_stall <= ($urandom_range(0, 3) == 0);
            2:       wr_stall <= ($urandom_range(0, 9) < 7);
            default: wr_stall <= ((cycle_count % 5) < 2);
        endcase
    end

    function automatic logic [4:0] left_semi_of(input logic [7:0] sc);
        logic [4:0] semi;
        semi = NO_SEMI;
        for (int i = 0; i < 17; i++)
            if (LEFT_CODES[i] == sc)
                semi = LEFT_SEMIS[i];
        return semi;
    endfunction

    function automatic logic [4:0] right_semi_of(input logic [7:0] sc);
        logic [4:0] semi;
        semi = NO_SEMI;
        for (int i = 0; i < 10; i++)
            if (RIGHT_CODES[i] == sc)
                semi = RIGHT_SEMIS[i];
        return semi;
    endfunction

    function automatic logic [31:0] note_phase(input logic [6:0] note);
        if (note < MIDI_LO || note > MIDI_HI)
            return 32'h0;
        return PHASE_ROM[note - MIDI_LO];
    endfunction

    function automatic wr_item_t reg_write(input logic [3:0] idx, input logic [31:0] data);
        wr_item_t w;
        w.reg_index  = idx;
        w.reg_data   = data;
        w.last_write = 1'b0;
        return w;
    endfunction

    function automatic key_item_t key_ev(input logic [7:0] sc, input logic pr,
                                         input logic [6:0] ch);
        key_item_t k;
        k.operation = OP_KEY;
        k.scancode  = sc;
        k.pressed   = pr;
        k.ascii     = ch;
        return k;
    endfunction

    task automatic reset_note_state();
        keys_live  = 1'b0;
        left_base  = BASE_RESET;
        right_base = BASE_RESET;
        fm_on      = 1'b0;
        left_hold  = NO_SEMI;
        right_hold = NO_SEMI;
        ctrl_copy  = CTRL_START;
    endtask

    task automatic push_osc_preset(ref wr_item_t w[$]);
        w.push_back(reg_write(REG_OSC_A, OSC_A_DATA));
        w.push_back(reg_write(REG_OSC_B, OSC_B_DATA));
        w.push_back(reg_write(REG_OSC_C, OSC_C_DATA));
        w.push_back(reg_write(REG_OSC_D, OSC_D_DATA));
        w.push_back(reg_write(REG_OSC_E, OSC_E_DATA));
        w.push_back(reg_write(REG_OSC_F, OSC_F_DATA));
    endtask

    // Register writes caused by one accepted key transaction
    task automatic predict_writes(input key_item_t k);
        wr_item_t   w[$];
        if (k.operation == OP_START)
        begin
            reset_note_state();
            w.push_back(reg_write(REG_CTRL, 32'(CTRL_START)));
            push_osc_preset(w);
            keys_live = 1'b1;
        end
        else if (!keys_live)
        begin
            // ignored while inactive
        end
        else if (!k.pressed)
        begin
            if (left_hold != NO_SEMI && left_semi_of(k.scancode) == left_hold)
            begin
                w.push_back(reg_write(REG_LEFT_NOTE, 32'h0));
                left_hold = NO_SEMI;
            end
            if (right_hold != NO_SEMI && right_semi_of(k.scancode) == right_hold)
            begin
                w.push_back(reg_write(REG_RIGHT_NOTE, 32'h0));
                right_hold = NO_SEMI;
            end
        end
        else if (k.scancode == SC_TAB)
        begin
            if (left_base > BASE_LOW)
                left_base = left_base - OCTAVE;
        end
        else if (k.scancode == SC_CAPSLOCK)
        begin
            if (left_base < BASE_HIGH)
                left_base = left_base + OCTAVE;
        end
        else if (k.scancode == SC_NUMLOCK)
        begin
            if (right_base < BASE_HIGH)
                right_base = right_base + OCTAVE;
        end
        else if (k.ascii == CH_Q_LO || k.ascii == CH_Q_UP)
        begin
            ctrl_copy = CTRL_MUTE;
            w.push_back(reg_write(REG_CTRL, 32'(CTRL_MUTE)));
            w.push_back(reg_write(REG_LEFT_NOTE, 32'h0));
            w.push_back(reg_write(REG_RIGHT_NOTE, 32'h0));
            keys_live = 1'b0;
        end
        else if (k.ascii == CH_M_LO || k.ascii == CH_M_UP)
        begin
            fm_on = ~fm_on;
            ctrl_copy = (ctrl_copy & ~3'b110) | {1'b0, fm_on, 1'b0};
            w.push_back(reg_write(REG_CTRL, 32'(ctrl_copy)));
            if (!fm_on)
                push_osc_preset(w);
            else
            begin
                w.push_back(reg_write(REG_FM_A, FM_A_DATA));
                w.push_back(reg_write(REG_FM_B, FM_B_DATA));
                w.push_back(reg_write(REG_FM_C, FM_C_DATA));
                w.push_back(reg_write(REG_FM_D, FM_D_DATA));
            end
        end
        else if (left_semi_of(k.scancode) != NO_SEMI)
        begin
            left_hold = left_semi_of(k.scancode);
            w.push_back(reg_write(REG_LEFT_NOTE, note_phase(left_base + {2'b00, left_hold})));
        end
        else if (right_semi_of(k.scancode) != NO_SEMI)
        begin
            right_hold = right_semi_of(k.scancode);
            w.push_back(reg_write(REG_RIGHT_NOTE,
                                  note_phase(right_base + {2'b00, right_hold})));
        end
        if (w.size() > 0)
            w[w.size() - 1].last_write = 1'b1;
        foreach (w[i])
            expected_writes.push_back(w[i]);
    endtask

    // Drive one transaction; sender idles between bursts of random length
    task automatic send_item(input key_item_t item);
        int gap;
        key_valid <= 1'b1;
        key_item  <= item;
        do
            @(posedge clk);
        while (key_stall);
        predict_writes(item);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic note_mismatch(input string what, input wr_item_t want, input wr_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t mismatch (%s): expected idx %0d data %h last %b, got idx %0d data %h last %b",
                     $realtime, what, want.reg_index, want.reg_data, want.last_write,
                     got.reg_index, got.reg_data, got.last_write);
    endtask

    // Compare each accepted write with the oldest expected one
    always @(posedge clk)
    begin : wr_check
        wr_item_t want;
        if (rst_n && wr_valid && !wr_stall)
        begin
            if (expected_writes.size() == 0)
            begin
                note_mismatch("unexpected write", '0, wr_item);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (wr_item.reg_index !== want.reg_index)
                    note_mismatch("reg_index", want, wr_item);
                else if (wr_item.reg_data !== want.reg_data)
                    note_mismatch("reg_data", want, wr_item);
                else if (wr_item.last_write !== want.last_write)
                    note_mismatch("last_write", want, wr_item);
            end
        end
    end

    // Keys before any start are ignored, quit included
    task automatic test_inactive_keys();
        send_item(key_ev(LEFT_CODES[0], 1'b1, CH_SPACE));
        send_item(key_ev(SC_KEY_Q, 1'b1, CH_Q_LO));
    endtask

    task automatic test_start();
        key_item_t k;
        k.operation = OP_START;
        k.scancode  = 8'hFF;
        k.pressed   = 1'b1;
        k.ascii     = 7'h7F;
        send_item(k);
    endtask

    // Left track: play, release, octave limits at both ends, note above the top
    task automatic test_left_track();
        send_item(key_ev(8'h1C, 1'b1, CH_SPACE));
        send_item(key_ev(8'h1C, 1'b0, CH_SPACE));
        repeat (3) send_item(key_ev(SC_TAB, 1'b1, CH_SPACE));
        send_item(key_ev(8'h1D, 1'b1, CH_SPACE));
        repeat (6) send_item(key_ev(SC_CAPSLOCK, 1'b1, CH_SPACE));
        send_item(key_ev(8'h44, 1'b1, CH_SPACE));
    endtask

    // Right track: octave up to the top, note out of range, matching release
    task automatic test_right_track();
        repeat (3) send_item(key_ev(SC_NUMLOCK, 1'b1, CH_SPACE));
        send_item(key_ev(8'h70, 1'b1, CH_SPACE));
        send_item(key_ev(8'h70, 1'b0, CH_SPACE));
    endtask

    task automatic test_mode_toggle();
        send_item(key_ev(SC_KEY_M, 1'b1, CH_M_UP));
        send_item(key_ev(SC_KEY_M, 1'b1, CH_M_LO));
    endtask

    task automatic test_unmapped_and_quit();
        send_item(key_ev(8'h00, 1'b1, 7'h00));
        send_item(key_ev(SC_KEY_Q, 1'b1, CH_Q_UP));
    endtask

    function automatic logic [7:0] left_code_for(input logic [4:0] semi);
        logic [7:0] sc;
        sc = LEFT_CODES[$urandom_range(0, 16)];
        for (int i = 0; i < 17; i++)
            if (LEFT_SEMIS[i] == semi)
                sc = LEFT_CODES[i];
        return sc;
    endfunction

    function automatic logic [7:0] right_code_for(input logic [4:0] semi);
        logic [7:0] sc;
        sc = RIGHT_CODES[$urandom_range(0, 9)];
        for (int i = 0; i < 10; i++)
            if (RIGHT_SEMIS[i] == semi)
                sc = RIGHT_CODES[i];
        return sc;
    endfunction

    // Mostly playing sequences with random content, some quit/mode keys and noise
    function automatic key_item_t make_random_item();
        key_item_t k;
        int        pick;
        k = key_ev(8'($urandom_range(0, 255)), 1'b1, 7'($urandom_range(0, 127)));
        pick = $urandom_range(0, 99);
        if ((!keys_live && $urandom_range(0, 1) == 0) || pick < 4)
        begin
            k.operation = OP_START;
            k.pressed   = 1'($urandom_range(0, 1));
        end
        else if (pick < 90)
        begin
            if (pick < 40)
                k.scancode = LEFT_CODES[$urandom_range(0, 16)];
            else if (pick < 55)
                k.scancode = RIGHT_CODES[$urandom_range(0, 9)];
            else if (pick < 75)
            begin
                k.pressed = 1'b0;
                if ($urandom_range(0, 1) == 0)
                    k.scancode = ($urandom_range(0, 2) != 0) ? left_code_for(left_hold)
                                                             : LEFT_CODES[$urandom_range(0, 16)];
                else
                    k.scancode = ($urandom_range(0, 2) != 0) ? right_code_for(right_hold)
                                                             : RIGHT_CODES[$urandom_range(0, 9)];
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       k.scancode = SC_TAB;
                    1:       k.scancode = SC_CAPSLOCK;
                    default: k.scancode = SC_NUMLOCK;
                endcase
            end
            // keep plain playing keys from turning into quit or mode keys
            if (k.ascii == CH_Q_LO || k.ascii == CH_Q_UP ||
                k.ascii == CH_M_LO || k.ascii == CH_M_UP)
                k.ascii = k.ascii ^ 7'h01;
        end
        else if (pick < 94)
        begin
            k.scancode = SC_KEY_M;
            k.ascii    = $urandom_range(0, 1) ? CH_M_LO : CH_M_UP;
        end
        else if (pick < 96)
        begin
            k.scancode = SC_KEY_Q;
            k.ascii    = $urandom_range(0, 1) ? CH_Q_LO : CH_Q_UP;
        end
        else
        begin
            k.pressed = 1'($urandom_range(0, 1));
        end
        return k;
    endfunction

    task automatic test_random_stream();
        key_item_t k;
        int        counted;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            k = make_random_item();
            if (k.operation == OP_START || keys_live)
                counted++;
            send_item(k);
        end
    endtask

    initial
    begin
        reset_note_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_inactive_keys();
        test_start();
        test_left_track();
        test_right_track();
        test_mode_toggle();
        test_unmapped_and_quit();
        test_random_stream();

        key_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_writes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
